### design/width_select_integer_alu_defines.svh
// Assertion macros for the width-select integer ALU.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef WIDTH_SELECT_INTEGER_ALU_DEFINES_SVH
`define WIDTH_SELECT_INTEGER_ALU_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge while out of reset.
`define WSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next cycle.
`define WSA_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`else
`define WSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define WSA_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg)
`endif
`endif

### design/wsa_pkg.sv
// Shared types, operation codes and width helpers of the width-select ALU.
// Used by the top level and by the pipelined divider; depends on nothing.
package wsa_pkg;

    localparam int DATA_WIDTH_DEF = 64;

    localparam logic [4:0] OP_UDIV = 5'd0;
    localparam logic [4:0] OP_SDIV = 5'd1;
    localparam logic [4:0] OP_UREM = 5'd2;
    localparam logic [4:0] OP_SREM = 5'd3;
    localparam logic [4:0] OP_MUL  = 5'd4;
    localparam logic [4:0] OP_SHL  = 5'd5;
    localparam logic [4:0] OP_LSHR = 5'd6;
    localparam logic [4:0] OP_ASHR = 5'd7;
    localparam logic [4:0] OP_AND  = 5'd8;
    localparam logic [4:0] OP_OR   = 5'd9;
    localparam logic [4:0] OP_XOR  = 5'd10;
    localparam logic [4:0] OP_ADD  = 5'd11;
    localparam logic [4:0] OP_SUB  = 5'd12;
    localparam logic [4:0] OP_EQ   = 5'd13;
    localparam logic [4:0] OP_NE   = 5'd14;
    localparam logic [4:0] OP_UGT  = 5'd15;
    localparam logic [4:0] OP_UGE  = 5'd16;
    localparam logic [4:0] OP_ULT  = 5'd17;
    localparam logic [4:0] OP_ULE  = 5'd18;
    localparam logic [4:0] OP_SGT  = 5'd19;
    localparam logic [4:0] OP_SGE  = 5'd20;
    localparam logic [4:0] OP_SLT  = 5'd21;
    localparam logic [4:0] OP_SLE  = 5'd22;

    localparam logic [2:0] SZ_1  = 3'd0;
    localparam logic [2:0] SZ_8  = 3'd1;
    localparam logic [2:0] SZ_16 = 3'd2;
    localparam logic [2:0] SZ_32 = 3'd3;

    typedef struct packed {
        logic [4:0]  action;
        logic [2:0]  size_code;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } wsa_in_t;

    typedef struct packed {
        logic [63:0] result;
        logic        div_zero_error;
    } wsa_out_t;

    // Sideband that rides along the divider stages.
    typedef struct packed {
        logic [4:0]  action;
        logic [2:0]  size_code;
        logic [63:0] other;
        logic        neg_q;
        logic        neg_r;
        logic        err;
    } wsa_side_t;

    function automatic logic [63:0] size_mask(input logic [2:0] sz);
        logic [63:0] m;
        case (sz)
            SZ_1:    m = 64'h1;
            SZ_8:    m = 64'hFF;
            SZ_16:   m = 64'hFFFF;
            SZ_32:   m = 64'hFFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] shift_mask(input logic [2:0] sz);
        logic [5:0] m;
        case (sz)
            SZ_1:    m = 6'd0;
            SZ_8:    m = 6'd7;
            SZ_16:   m = 6'd15;
            SZ_32:   m = 6'd31;
            default: m = 6'd63;
        endcase
        return m;
    endfunction

endpackage

### design/width_select_integer_alu.sv
// Top level of the width-select integer ALU: operand extension, multiplier and
// simple operations, then the pipelined divider from wsa_div_pipe; uses wsa_pkg.
//
//   channel   signals                 direction   handshake
//   request   start, busy, req        in          start && !busy
//   response  done, rsp               out         done (one cycle)
//
// A transaction accepted at one clock edge passes through three front stages
// (extend, compute, multiply sum), one divider stage per quotient bit, and the
// output register before its response shows. A new transaction may enter every
// cycle; busy is held low. Reset empties the pipeline of valid bits and the
// receiver cannot stall the response.
`include "width_select_integer_alu_defines.svh"
module width_select_integer_alu
    import wsa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  wsa_in_t  req,
    output logic     done,
    output wsa_out_t rsp
);

    localparam int LATENCY = DATA_WIDTH + 4;

    // Stage 1: captured request.
    logic        s1_vld_reg;
    wsa_in_t     s1_reg;
    logic        s1_sgn;
    logic [63:0] s1_mask;
    logic [63:0] s1_az;
    logic [63:0] s1_bz;
    logic [63:0] s1_a_ext;
    logic [63:0] s1_b_ext;
    logic [5:0]  s1_sh;

    // Stage 2: extended operands.
    logic        s2_vld_reg;
    logic [4:0]  s2_act_reg;
    logic [2:0]  s2_size_reg;
    logic [63:0] s2_a_reg;
    logic [63:0] s2_b_reg;
    logic [5:0]  s2_sh_reg;
    logic [63:0] s2_simple;
    logic [63:0] s2_p0;
    logic [63:0] s2_p1;
    logic [63:0] s2_p2;
    logic        s2_sgn;

    // Stage 3: products and divider operands.
    logic        s3_vld_reg;
    logic [4:0]  s3_act_reg;
    logic [2:0]  s3_size_reg;
    logic [63:0] s3_simple_reg;
    logic [63:0] s3_p0_reg;
    logic [31:0] s3_p1_reg;
    logic [31:0] s3_p2_reg;
    logic [63:0] s3_mag_a_reg;
    logic [63:0] s3_mag_b_reg;
    logic        s3_neg_q_reg;
    logic        s3_neg_r_reg;
    logic        s3_bzero_reg;
    logic [31:0] s3_cross;
    logic [63:0] s3_mul;
    wsa_side_t   s3_side;

    logic                  dv_vld;
    logic [DATA_WIDTH-1:0] dv_q;
    logic [DATA_WIDTH-1:0] dv_r;
    wsa_side_t             dv_side;
    logic [63:0]           fin_res;

    logic     done_reg;
    wsa_out_t rsp_reg;
    wsa_out_t rsp_next;

    assign busy = 1'b0;

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= req;
    end

    always_comb
    begin
        s1_sgn = (s1_reg.action == OP_SDIV) || (s1_reg.action == OP_SREM) ||
                 (s1_reg.action == OP_ASHR) || (s1_reg.action == OP_SGT) ||
                 (s1_reg.action == OP_SGE)  || (s1_reg.action == OP_SLT) ||
                 (s1_reg.action == OP_SLE);
        s1_mask = size_mask(s1_reg.size_code);
        s1_az   = s1_reg.operand_a & s1_mask;
        s1_bz   = s1_reg.operand_b & s1_mask;
        // The top bit of the width is the one that the mask shifted right drops.
        s1_a_ext = (s1_sgn && ((s1_az & ~(s1_mask >> 1)) != '0)) ? (s1_az | ~s1_mask) : s1_az;
        s1_b_ext = (s1_sgn && ((s1_bz & ~(s1_mask >> 1)) != '0)) ? (s1_bz | ~s1_mask) : s1_bz;
        s1_sh    = s1_reg.operand_b[5:0] & shift_mask(s1_reg.size_code);
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_act_reg  <= s1_reg.action;
        s2_size_reg <= s1_reg.size_code;
        s2_a_reg    <= s1_a_ext;
        s2_b_reg    <= s1_b_ext;
        s2_sh_reg   <= s1_sh;
    end

    always_comb
    begin
        case (s2_act_reg)
            OP_SHL:  s2_simple = s2_a_reg << s2_sh_reg;
            OP_LSHR: s2_simple = s2_a_reg >> s2_sh_reg;
            OP_ASHR: s2_simple = $unsigned($signed(s2_a_reg) >>> s2_sh_reg);
            OP_AND:  s2_simple = s2_a_reg & s2_b_reg;
            OP_OR:   s2_simple = s2_a_reg | s2_b_reg;
            OP_XOR:  s2_simple = s2_a_reg ^ s2_b_reg;
            OP_ADD:  s2_simple = s2_a_reg + s2_b_reg;
            OP_SUB:  s2_simple = s2_a_reg - s2_b_reg;
            OP_EQ:   s2_simple = {63'd0, s2_a_reg == s2_b_reg};
            OP_NE:   s2_simple = {63'd0, s2_a_reg != s2_b_reg};
            OP_UGT:  s2_simple = {63'd0, s2_a_reg > s2_b_reg};
            OP_UGE:  s2_simple = {63'd0, s2_a_reg >= s2_b_reg};
            OP_ULT:  s2_simple = {63'd0, s2_a_reg < s2_b_reg};
            OP_ULE:  s2_simple = {63'd0, s2_a_reg <= s2_b_reg};
            OP_SGT:  s2_simple = {63'd0, $signed(s2_a_reg) > $signed(s2_b_reg)};
            OP_SGE:  s2_simple = {63'd0, $signed(s2_a_reg) >= $signed(s2_b_reg)};
            OP_SLT:  s2_simple = {63'd0, $signed(s2_a_reg) < $signed(s2_b_reg)};
            OP_SLE:  s2_simple = {63'd0, $signed(s2_a_reg) <= $signed(s2_b_reg)};
            default: s2_simple = '0;
        endcase
        // Low half of the 64x64 product from three 32x32 partial products.
        s2_p0  = s2_a_reg[31:0] * s2_b_reg[31:0];
        s2_p1  = s2_a_reg[31:0] * s2_b_reg[63:32];
        s2_p2  = s2_a_reg[63:32] * s2_b_reg[31:0];
        s2_sgn = (s2_act_reg == OP_SDIV) || (s2_act_reg == OP_SREM);
    end

    // ---------------- stage 3 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_act_reg    <= s2_act_reg;
        s3_size_reg   <= s2_size_reg;
        s3_simple_reg <= s2_simple;
        s3_p0_reg     <= s2_p0;
        s3_p1_reg     <= s2_p1[31:0];
        s3_p2_reg     <= s2_p2[31:0];
        s3_mag_a_reg  <= (s2_sgn && s2_a_reg[63]) ? (64'd0 - s2_a_reg) : s2_a_reg;
        s3_mag_b_reg  <= (s2_sgn && s2_b_reg[63]) ? (64'd0 - s2_b_reg) : s2_b_reg;
        s3_neg_q_reg  <= s2_sgn && (s2_a_reg[63] ^ s2_b_reg[63]);
        s3_neg_r_reg  <= s2_sgn && s2_a_reg[63];
        s3_bzero_reg  <= (s2_b_reg == '0);
    end

    always_comb
    begin
        s3_cross          = s3_p1_reg + s3_p2_reg;
        s3_mul            = s3_p0_reg + {s3_cross, 32'd0};
        s3_side.action    = s3_act_reg;
        s3_side.size_code = s3_size_reg;
        s3_side.other     = (s3_act_reg == OP_MUL) ? s3_mul : s3_simple_reg;
        s3_side.neg_q     = s3_neg_q_reg;
        s3_side.neg_r     = s3_neg_r_reg;
        s3_side.err       = (s3_act_reg <= OP_SREM) && s3_bzero_reg;
    end

    wsa_div_pipe #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (s3_vld_reg),
        .dividend  (s3_mag_a_reg[DATA_WIDTH-1:0]),
        .divisor   (s3_mag_b_reg[DATA_WIDTH-1:0]),
        .side_in   (s3_side),
        .out_vld   (dv_vld),
        .quotient  (dv_q),
        .remainder (dv_r),
        .side_out  (dv_side)
    );

    // ---------------- output stage ----------------
    always_comb
    begin
        case (dv_side.action)
            OP_UDIV: fin_res = 64'(dv_q);
            OP_SDIV: fin_res = dv_side.neg_q ? (64'd0 - 64'(dv_q)) : 64'(dv_q);
            OP_UREM: fin_res = 64'(dv_r);
            OP_SREM: fin_res = dv_side.neg_r ? (64'd0 - 64'(dv_r)) : 64'(dv_r);
            default: fin_res = dv_side.other;
        endcase
        rsp_next.result         = dv_side.err ? 64'd0 : (fin_res & size_mask(dv_side.size_code));
        rsp_next.div_zero_error = dv_side.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `WSA_ASSERT(a_err_zero, clk, rst_n, (done && rsp.div_zero_error) |-> (rsp.result == '0), "divide error with nonzero result")
    `WSA_ASSERT(a_never_busy, clk, rst_n, !busy, "busy raised")
    `WSA_ASSERT(a_latency, clk, rst_n, (start && !busy) |-> ##(LATENCY) done, "response missing after fixed latency")
    `WSA_ASSERT_NEXT(a_div_to_done, clk, rst_n, dv_vld, done, "divider output not registered to done")

endmodule

### design/wsa_div_pipe.sv
// Restoring divider pipeline, one quotient bit per register stage.
// Carries a wsa_pkg sideband struct alongside each transaction.
module wsa_div_pipe
    import wsa_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    input  wsa_side_t             side_in,
    output logic                  out_vld,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder,
    output wsa_side_t             side_out
);

    localparam int N = DATA_WIDTH;

    logic            vld_reg  [1:N];
    logic [N-1:0]    rem_reg  [1:N];
    logic [N-1:0]    dq_reg   [1:N];
    logic [N-1:0]    dsr_reg  [1:N];
    wsa_side_t       side_reg [1:N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic         cur_vld;
            logic [N-1:0] cur_rem;
            logic [N-1:0] cur_dq;
            logic [N-1:0] cur_dsr;
            wsa_side_t    cur_side;
            logic [N:0]   shifted;
            logic [N:0]   diff;
            logic         ge;
            logic [N-1:0] rem_next;
            logic [N-1:0] dq_next;

            if (i == 0)
            begin : g_first
                assign cur_vld  = in_vld;
                assign cur_rem  = '0;
                assign cur_dq   = dividend;
                assign cur_dsr  = divisor;
                assign cur_side = side_in;
            end
            else
            begin : g_rest
                assign cur_vld  = vld_reg[i];
                assign cur_rem  = rem_reg[i];
                assign cur_dq   = dq_reg[i];
                assign cur_dsr  = dsr_reg[i];
                assign cur_side = side_reg[i];
            end

            // The partial remainder stays below the divisor, so one extra bit suffices.
            assign shifted  = {cur_rem, cur_dq[N-1]};
            assign diff     = shifted - {1'b0, cur_dsr};
            assign ge       = ~diff[N];
            assign rem_next = ge ? diff[N-1:0] : shifted[N-1:0];
            assign dq_next  = {cur_dq[N-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i+1] <= 1'b0;
                end
                else
                begin
                    vld_reg[i+1] <= cur_vld;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i+1]  <= rem_next;
                dq_reg[i+1]   <= dq_next;
                dsr_reg[i+1]  <= cur_dsr;
                side_reg[i+1] <= cur_side;
            end
        end
    endgenerate

    assign out_vld   = vld_reg[N];
    assign quotient  = dq_reg[N];
    assign remainder = rem_reg[N];
    assign side_out  = side_reg[N];

endmodule
